// File: rtl/b64_pkg.sv
package b64_pkg;

  localparam int TBL_DEPTH = 65;
  localparam int IDX_W     = 7;
  localparam int JQ_DEPTH  = 4;
  localparam int JQ_PTR_W  = 2;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PTR_W  = 2;

  localparam logic [IDX_W-1:0] PAD_IDX = 7'd64;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  // One queued job: a table write, or a run of one to three lookups.
  typedef struct packed {
    logic                      is_load;
    logic [1:0]                cnt_m1;
    logic [2:0][IDX_W-1:0]     idx;
    logic [7:0]                wchar;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jq_stat_t;

  // Standard alphabet, pad '=' at index 64.
  function automatic logic [7:0] std_char(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    c = {1'b0, i};
    if (i < 7'd26) begin
      std_char = 8'h41 + c;
    end else if (i < 7'd52) begin
      std_char = 8'h61 + c - 8'd26;
    end else if (i < 7'd62) begin
      std_char = 8'h30 + c - 8'd52;
    end else if (i == 7'd62) begin
      std_char = 8'h2b;
    end else if (i == 7'd63) begin
      std_char = 8'h2f;
    end else begin
      std_char = 8'h3d;
    end
  endfunction

endpackage

// File: rtl/b64_front.sv
module b64_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        in_req_type,
  input  logic [6:0]        in_table_index,
  input  logic [7:0]        in_table_char,
  input  logic [7:0]        in_data_byte,
  input  b64_pkg::jq_stat_t jq_stat,
  output logic              jq_push,
  output b64_pkg::job_t     jq_job
);

  localparam logic [1:0] PH_ONE = 2'd1;
  localparam logic [1:0] PH_TWO = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic       acc;

  assign acc = push & ~jq_stat.full;

  always_comb begin
    jq_job    = '0;
    jq_push   = 1'b0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    if (acc) begin
      unique case (in_req_type)
        b64_pkg::REQ_LOAD: begin
          if (in_table_index <= b64_pkg::PAD_IDX) begin
            jq_job.is_load = 1'b1;
            jq_job.idx[0]  = in_table_index;
            jq_job.wchar   = in_table_char;
            jq_push        = 1'b1;
          end
        end
        b64_pkg::REQ_DATA: begin
          jq_push = 1'b1;
          unique case (phase_r)
            PH_ONE: begin
              jq_job.idx[0] = {1'b0, carry_r[1:0], in_data_byte[7:4]};
              carry_nxt     = in_data_byte[3:0];
              phase_nxt     = PH_TWO;
            end
            PH_TWO: begin
              jq_job.cnt_m1 = 2'd1;
              jq_job.idx[0] = {1'b0, carry_r, in_data_byte[7:6]};
              jq_job.idx[1] = {1'b0, in_data_byte[5:0]};
              carry_nxt     = 4'd0;
              phase_nxt     = 2'd0;
            end
            default: begin
              jq_job.idx[0] = {1'b0, in_data_byte[7:2]};
              carry_nxt     = {2'b00, in_data_byte[1:0]};
              phase_nxt     = PH_ONE;
            end
          endcase
        end
        b64_pkg::REQ_END: begin
          unique case (phase_r)
            PH_ONE: begin
              jq_push       = 1'b1;
              jq_job.cnt_m1 = 2'd2;
              jq_job.idx[0] = {1'b0, carry_r[1:0], 4'd0};
              jq_job.idx[1] = b64_pkg::PAD_IDX;
              jq_job.idx[2] = b64_pkg::PAD_IDX;
            end
            PH_TWO: begin
              jq_push       = 1'b1;
              jq_job.cnt_m1 = 2'd1;
              jq_job.idx[0] = {1'b0, carry_r, 2'd0};
              jq_job.idx[1] = b64_pkg::PAD_IDX;
            end
            default: begin
            end
          endcase
          phase_nxt = 2'd0;
          carry_nxt = 4'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      carry_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// File: rtl/b64_job_q.sv
module b64_job_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              jq_push,
  input  b64_pkg::job_t     jq_job,
  input  logic              jq_pop,
  output b64_pkg::job_t     jq_head,
  output b64_pkg::jq_stat_t jq_stat
);

  b64_pkg::job_t                  q_mem [b64_pkg::JQ_DEPTH];
  logic [b64_pkg::JQ_PTR_W-1:0]   wp_r, rp_r;
  logic [b64_pkg::JQ_PTR_W:0]     cnt_r;
  logic                           do_push, do_pop;

  assign jq_stat.full  = (cnt_r == (b64_pkg::JQ_PTR_W+1)'(b64_pkg::JQ_DEPTH));
  assign jq_stat.empty = (cnt_r == '0);
  assign do_push       = jq_push & ~jq_stat.full;
  assign do_pop        = jq_pop & ~jq_stat.empty;
  assign jq_head       = q_mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wp_r] <= jq_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/b64_back.sv
module b64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64_pkg::jq_stat_t jq_stat,
  input  b64_pkg::job_t     jq_head,
  output logic              jq_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_char,
  output logic              out_run_last
);

  // Alphabet store; an entry never written reads as the standard character.
  logic [7:0]                   alphabet [b64_pkg::TBL_DEPTH];
  logic [b64_pkg::TBL_DEPTH-1:0] wr_vld_r;

  logic [1:0]                   sel_r, sel_nxt;
  logic                         rd_vld_r, rd_last_r, rd_hit_r;
  logic [7:0]                   rd_mem_r, rd_std_r;

  logic [7:0]                   oq_char [b64_pkg::OQ_DEPTH];
  logic                         oq_last [b64_pkg::OQ_DEPTH];
  logic [b64_pkg::OQ_PTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [b64_pkg::OQ_PTR_W:0]   oq_cnt_r;

  logic                         credit, issue, do_load, is_last, oq_rd;
  logic [b64_pkg::IDX_W-1:0]    rd_idx;

  // Reserve a slot for the lookup in flight.
  assign credit  = ((oq_cnt_r + {{b64_pkg::OQ_PTR_W{1'b0}}, rd_vld_r})
                    < (b64_pkg::OQ_PTR_W+1)'(b64_pkg::OQ_DEPTH));
  assign do_load = ~jq_stat.empty & jq_head.is_load;
  assign issue   = ~jq_stat.empty & ~jq_head.is_load & credit;
  assign rd_idx  = jq_head.idx[sel_r];
  assign is_last = (sel_r == jq_head.cnt_m1);
  assign jq_pop  = do_load | (issue & is_last);
  assign sel_nxt = (issue & ~is_last) ? sel_r + 1'b1 : (issue ? 2'd0 : sel_r);

  assign empty        = (oq_cnt_r == '0);
  assign oq_rd        = pop & ~empty;
  assign out_char     = oq_char[oq_rp_r];
  assign out_run_last = oq_last[oq_rp_r];

  always_ff @(posedge clk) begin
    if (do_load) begin
      alphabet[jq_head.idx[0]] <= jq_head.wchar;
    end
    if (issue) begin
      rd_mem_r  <= alphabet[rd_idx];
      rd_std_r  <= b64_pkg::std_char(rd_idx);
      rd_hit_r  <= wr_vld_r[rd_idx];
      rd_last_r <= is_last;
    end
    if (rd_vld_r) begin
      oq_char[oq_wp_r] <= rd_hit_r ? rd_mem_r : rd_std_r;
      oq_last[oq_wp_r] <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= '0;
      sel_r    <= 2'd0;
      rd_vld_r <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (do_load) begin
        wr_vld_r[jq_head.idx[0]] <= 1'b1;
      end
      sel_r    <= sel_nxt;
      rd_vld_r <= issue;
      if (rd_vld_r) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_rd) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      unique case ({rd_vld_r, oq_rd})
        2'b10:   oq_cnt_r <= oq_cnt_r + 1'b1;
        2'b01:   oq_cnt_r <= oq_cnt_r - 1'b1;
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/base64_stream_encoder_top.sv
// Streaming Base64 encoder with a loadable 65-entry alphabet.
// Input side is a queue: present an item on in_* and raise push; it transfers
// at a clock edge where push is high and full is low. Items are alphabet loads,
// message bytes or end-of-message marks. Loads above entry 64 and request
// type 3 are dropped.
// Result side is a queue as well: while empty is low, out_char and
// out_run_last carry the oldest character; raise pop to transfer it.
// out_run_last marks the final character caused by one input item.
// A character passes the job queue, the lookup registers and the output queue.
// Flow: the front takes one item per cycle, while full is low, into a four-deep
// job queue; the back does one table write, or one alphabet lookup while the
// output queue has room, per cycle, so a byte needs one or two lookups and a
// flush up to three; a byte stream needs four lookups for every three bytes.
// A stalled receiver fills the four-entry output queue, then the job queue,
// then full rises; nothing is lost.
// Reset (rst_n low, synchronous) empties both queues, clears the group phase
// and restores the standard alphabet with '=' as pad.
module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_req_type,
  input  logic [6:0] in_table_index,
  input  logic [7:0] in_table_char,
  input  logic [7:0] in_data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_run_last
);

  b64_pkg::jq_stat_t jq_stat;
  b64_pkg::job_t     jq_job, jq_head;
  logic              jq_push, jq_pop;

  assign full = jq_stat.full;

  // Front: hold phase and leftover bits, make at most one job per accepted item.
  b64_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_req_type    (in_req_type),
    .in_table_index (in_table_index),
    .in_table_char  (in_table_char),
    .in_data_byte   (in_data_byte),
    .jq_stat        (jq_stat),
    .jq_push        (jq_push),
    .jq_job         (jq_job)
  );

  // Job queue decouples classification from lookup.
  b64_job_q u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .jq_push (jq_push),
    .jq_job  (jq_job),
    .jq_pop  (jq_pop),
    .jq_head (jq_head),
    .jq_stat (jq_stat)
  );

  // Back: table writes, or lookups while output has room, one per cycle.
  b64_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .jq_stat      (jq_stat),
    .jq_head      (jq_head),
    .jq_pop       (jq_pop),
    .pop          (pop),
    .empty        (empty),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

  // Backpressure only comes from a populated job queue.
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !jq_stat.empty)
    else $error("full raised with empty job queue");

  // The back never retires a job that is not there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |-> !jq_stat.empty)
    else $error("job retired from empty queue");

  // The front only enqueues on a transfer.
  a_push_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    jq_push |-> (push && !full))
    else $error("job enqueued without an input transfer");

  // Reset drains the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule
